[design/sigmoid_xent_row_loss_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sigmoid cross-entropy row loss block
// Clocked property wrappers, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef SIGMOID_XENT_ROW_LOSS_CORE_ASSERT_SVH
`define SIGMOID_XENT_ROW_LOSS_CORE_ASSERT_SVH

// Check a property on every rising clk edge outside reset.
`define SXRL_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sxrl assertion failed");

// Check a property on every rising clk edge, reset included.
`define SXRL_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("sxrl assertion failed");

`endif

[design/sxrl_pkg.sv]
// ----------------------------------------------------------------------------
// sxrl_pkg
// Shared types, constants and the softplus table of the row loss block.
// ----------------------------------------------------------------------------
package sxrl_pkg;

  localparam int MAX_ROW_LENGTH = 4096;
  localparam int SP_DEPTH = 256;
  localparam int SP_IDX_W = $clog2(SP_DEPTH);
  localparam int CNT_W = $clog2(MAX_ROW_LENGTH) + 1;
  localparam int SUM_W = 56;
  localparam int TERM_W = 42;
  localparam int QUOT_W = SUM_W - 8;
  localparam int DIV_CNT_W = $clog2(QUOT_W + 1);

  localparam logic [1:0] MODE_STD = 2'd0;
  localparam logic [1:0] MODE_LOGD = 2'd1;
  localparam logic [1:0] MODE_UNJOINED = 2'd2;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef logic [15:0] sp_tab_t [SP_DEPTH];

  typedef struct packed {
    logic load;
    logic term;
    logic mul;
    logic acc;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic out_free;
  } status_t;

  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sp_tab_t build_sp_table();
    longint unsigned c;
    longint unsigned tt;
    longint unsigned p;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned pw;
    longint unsigned acc;
    sp_tab_t tab;
    c = ONE_Q30;
    tt = ONE_Q30;
    for (int k = 1; k <= 12; k++) begin
      tt = udiv(tt, 64'(32 * k));
      if (k[0]) begin
        c = c - tt;
      end else begin
        c = c + tt;
      end
    end
    p = ONE_Q30;
    for (int i = 0; i < SP_DEPTH; i++) begin
      if (i > 0) begin
        p = (p * c + (ONE_Q30 >> 1)) >> 30;
      end
      z = udiv(p << 30, (ONE_Q30 << 1) + p);
      z2 = (z * z) >> 30;
      pw = z;
      acc = 0;
      for (int n = 1; n <= 39; n += 2) begin
        acc = acc + udiv(pw, 64'(n));
        pw = (pw * z2) >> 30;
      end
      tab[i] = 16'(((acc << 1) + (64'd1 << 13)) >> 14);
    end
    return tab;
  endfunction

  localparam sp_tab_t SP_TABLE = build_sp_table();

endpackage

[design/sxrl_ctrl.sv]
// ----------------------------------------------------------------------------
// sxrl_ctrl
// Sequencer: element load, term, weight multiply, accumulate, divide, emit.
// ----------------------------------------------------------------------------
module sxrl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  sxrl_pkg::status_t status,
  output sxrl_pkg::cmd_t    cmd
);
  import sxrl_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TERM = 3'd1;
  localparam logic [2:0] ST_MUL = 3'd2;
  localparam logic [2:0] ST_ACC = 3'd3;
  localparam logic [2:0] ST_DIV = 3'd4;
  localparam logic [2:0] ST_FIN = 3'd5;
  localparam logic [2:0] ST_DIV_INIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          state_next = ST_TERM;
        end
      end
      ST_TERM: begin
        cmd.term = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        state_next = status.last ? ST_DIV_INIT : ST_IDLE;
      end
      ST_DIV_INIT: begin
        cmd.div_start = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/sxrl_dp.sv]
// ----------------------------------------------------------------------------
// sxrl_dp
// Term arithmetic, row accumulator, restoring divider and output register.
// ----------------------------------------------------------------------------
module sxrl_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_wdata,
  input  logic [47:0]      s_tdata,
  input  logic             s_tlast,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [31:0]      m_tdata,
  input  sxrl_pkg::cmd_t    cmd,
  output sxrl_pkg::status_t status
);
  import sxrl_pkg::*;

  logic [1:0] loss_mode;
  logic signed [15:0] x_r;
  logic [15:0] t_r;
  logic [15:0] w_r;
  logic last_r;
  logic [15:0] sp_r;
  logic signed [TERM_W-1:0] term;
  logic [39:0] pl;
  logic signed [34:0] ph;
  logic signed [SUM_W-1:0] term_sum;
  logic [CNT_W-1:0] element_count;
  logic sign_r;
  logic [QUOT_W-1:0] quot;
  logic [CNT_W-1:0] rem;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Input decode
  logic signed [15:0] in_x;
  logic [15:0] in_t;
  logic [16:0] in_ax;
  logic [13:0] in_idx;
  assign in_x = s_tdata[15:0];
  assign in_t = (s_tdata[31:16] > 16'd32768) ? 16'd32768 : s_tdata[31:16];
  assign in_ax = in_x[15] ? (17'd0 - {in_x[15], in_x}) : {1'b0, in_x};
  assign in_idx = in_ax[16:3];

  // Term operands
  logic s_pos;
  logic signed [16:0] t_s;
  logic signed [16:0] two_t;
  logic signed [24:0] x_sh;
  logic signed [24:0] d_logd;
  logic signed [16:0] op_a;
  logic signed [24:0] op_b;
  logic signed [16:0] op_c;
  logic signed [41:0] prod_a;
  logic signed [34:0] prod_b;
  logic signed [TERM_W-1:0] term_next;

  assign s_pos = ~x_r[15];
  assign t_s = signed'({1'b0, t_r});
  assign two_t = signed'({t_r, 1'b0}) - 17'sd32768;
  assign x_sh = {{1{x_r[15]}}, x_r, 8'd0};
  assign d_logd = (s_pos ? 25'sd0 : x_sh) - signed'({9'd0, sp_r});

  always_comb begin
    unique case (loss_mode)
      MODE_LOGD: begin
        op_a = two_t;
        op_b = d_logd;
        op_c = 17'sd0;
      end
      MODE_UNJOINED: begin
        op_a = s_pos ? two_t : t_s;
        op_b = x_sh;
        op_c = 17'sd32768 - t_s;
      end
      default: begin
        op_a = s_pos ? (t_s - 17'sd32768) : t_s;
        op_b = x_sh;
        op_c = 17'sd32768;
      end
    endcase
  end

  assign prod_a = 42'(op_a * op_b);
  assign prod_b = 35'(op_c * signed'({1'b0, sp_r}));
  assign term_next = prod_a - TERM_W'(prod_b);

  // Weighted term and accumulate
  logic signed [57:0] wprod;
  logic signed [42:0] inc;
  assign wprod = (58'(ph) <<< 24) + signed'(58'(pl));
  assign inc = 43'(wprod >>> 15);

  // Divider
  logic [SUM_W-1:0] mag;
  logic [CNT_W:0] trial;
  logic [CNT_W:0] diff;
  assign mag = term_sum[SUM_W-1] ? (SUM_W'(0) - unsigned'(term_sum)) : unsigned'(term_sum);
  assign trial = {rem, quot[QUOT_W-1]};
  assign diff = trial - {1'b0, element_count};

  // Result
  logic [31:0] res;
  always_comb begin
    if (element_count == '0) begin
      res = 32'd0;
    end else if (sign_r) begin
      res = (quot > QUOT_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : quot[31:0];
    end else begin
      res = (quot > QUOT_W'(33'h0_8000_0000)) ? 32'h8000_0000 : (32'd0 - quot[31:0]);
    end
  end

  assign status.last = last_r;
  assign status.div_done = (div_cnt == DIV_CNT_W'(QUOT_W));
  assign status.out_free = ~m_tvalid | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_mode <= MODE_STD;
      term_sum <= '0;
      element_count <= '0;
      m_tvalid <= 1'b0;
      div_cnt <= '0;
    end else begin
      if (cfg_we) begin
        loss_mode <= cfg_wdata;
      end
      if (cmd.acc && (element_count < CNT_W'(MAX_ROW_LENGTH))) begin
        term_sum <= term_sum + SUM_W'(inc);
        element_count <= element_count + 1'b1;
      end
      if (cmd.div_start) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        term_sum <= '0;
        element_count <= '0;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_x;
      t_r <= in_t;
      w_r <= s_tdata[47:32];
      last_r <= s_tlast;
      sp_r <= (in_idx < 14'(SP_DEPTH)) ? SP_TABLE[in_idx[SP_IDX_W-1:0]] : 16'd0;
    end
    if (cmd.term) begin
      term <= term_next;
    end
    if (cmd.mul) begin
      pl <= 40'(unsigned'(term[23:0]) * w_r);
      ph <= 35'(signed'(term[41:24]) * signed'({1'b0, w_r}));
    end
    if (cmd.div_start) begin
      sign_r <= term_sum[SUM_W-1];
      quot <= mag[SUM_W-1:8];
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!diff[CNT_W]) begin
        rem <= diff[CNT_W-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b1};
      end else begin
        rem <= trial[CNT_W-1:0];
        quot <= {quot[QUOT_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      m_tdata <= res;
    end
  end

endmodule

[design/sigmoid_xent_row_loss_core.sv]
// ----------------------------------------------------------------------------
// sigmoid_xent_row_loss_core
// Weighted sigmoid cross-entropy terms, accumulated per row; emits the
// negated row mean in Q16.16 on the element that ends the row.
//
//   channel | dir | fields (low bit first)
//   s_*     | in  | tdata: logit[15:0] target[31:16] weight[47:32]; tlast: row_end
//   m_*     | out | tdata: row_loss[31:0]
//   cfg_*   | in  | wdata: loss_mode[1:0]
//
// An element is handled in order: load with table lookup, term, weight
// multiply, accumulate. A row end then starts the divider, runs the
// one-bit-per-cycle divider (48 steps and a done check) and loads the
// output register, which waits while the previous result is not taken.
// The next row starts once the result is loaded.
// Reset is synchronous and clears the row sum, count, mode and output valid.
// ----------------------------------------------------------------------------
module sigmoid_xent_row_loss_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,   // loss_mode
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,     // logit, target, weight
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata      // row_loss
);
  import sxrl_pkg::*;

  cmd_t cmd;
  status_t status;

  sxrl_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status(status),
    .cmd(cmd)
  );

  sxrl_dp u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cmd(cmd),
    .status(status)
  );

endmodule

[design/sxrl_checker.sv]
// ----------------------------------------------------------------------------
// sxrl_checker
// Port-level checks of the row loss block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sigmoid_xent_row_loss_core_assert.svh"

module sxrl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  `SXRL_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !m_tvalid)
  `SXRL_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
  `SXRL_ASSERT(a_one_at_a_time, (s_tvalid && s_tready) |=> !s_tready)

endmodule

bind sigmoid_xent_row_loss_core sxrl_checker u_sxrl_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);
